// ===== design/bni_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bni_pkg;

    // Sizing
    localparam int unsigned MAX_CHANNELS = 256;
    localparam int unsigned FRAC_BITS    = 16;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned ADDR_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned ACT_MAX      = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;

    // Register file
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_NUM_CHANNELS = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_EPSILON      = REG_IDX_W'(1);

    // Request modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Saturation limits
    localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Root and divide unit
    localparam int unsigned SQ_STEPS = (DATA_W + FRAC_BITS + 1) / 2;
    localparam int unsigned X_W      = 2 * SQ_STEPS;
    localparam int unsigned ROOT_W   = SQ_STEPS;
    localparam int unsigned DVD_W    = DATA_W + FRAC_BITS;
    localparam int unsigned CNT_W    = $clog2(DVD_W + 1);

    // Normalise datapath
    localparam int unsigned DH_W  = DATA_W + 1 - FRAC_BITS;
    localparam int unsigned PH_W  = DH_W + DATA_W;
    localparam int unsigned PL_W  = FRAC_BITS + DATA_W;
    localparam int unsigned PM_W  = PH_W;
    localparam int unsigned SUM_W = PM_W + 1;

    typedef struct packed {
        logic               mode;
        logic [7:0]         load_channel;
        logic signed [31:0] mean_value;
        logic [30:0]        variance_value;
        logic signed [31:0] scale_value;
        logic signed [31:0] shift_value;
        logic signed [31:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result;
        logic [7:0]         result_channel;
        logic               last_channel;
    } t_out_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] mean;
        logic signed [DATA_W-1:0] factor;
        logic signed [DATA_W-1:0] shift;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] result;
    } t_norm_out;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] factor;
    } t_factor_out;

endpackage

`default_nettype wire

// ===== design/batch_norm_inference_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                      Payload
// input     in         i_in_valid / o_in_ready        i_in_data  (t_in_item)
// output    out        o_out_valid / i_out_ready      o_out_data (t_out_item)
// config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A sample request passes the table read and the normalise pipe (difference, magnitudes,
// partial products, sum, saturate) into the output register; the next request waits until then.
// A load request runs through the root and divide unit (24 root steps, 48 quotient steps
// unless the root is zero, then clamp and table write).
// Reset clears control state only; table entries are undefined until loaded, no clearing pass.
// A result waiting in the output register does not block the next request; a further result
// waits in the last pipe stage until the output register frees.

module batch_norm_inference_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire bni_pkg::t_in_item             i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output bni_pkg::t_out_item                 o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bni_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_NORM = 3'b010,
        ST_LOAD = 3'b100
    } t_state;

    t_state                              r_state, n_state;
    logic [8:0]                          r_num_channels;
    logic [15:0]                         r_epsilon;
    logic [7:0]                          r_counter;
    logic                                r_norm_start;
    logic signed [31:0]                  r_sample;
    logic [7:0]                          r_res_chan;
    logic                                r_res_last;
    logic signed [bni_pkg::DATA_W-1:0]   r_ld_mean;
    logic signed [bni_pkg::DATA_W-1:0]   r_ld_shift;
    logic [bni_pkg::ADDR_W-1:0]          r_ld_addr;
    logic                                r_ld_ok;
    logic                                r_out_valid;
    bni_pkg::t_out_item                  r_out;

    logic                                w_cfg_wr;
    logic [bni_pkg::REG_IDX_W-1:0]       w_reg_idx;
    logic [8:0]                          w_active;
    logic [7:0]                          w_chan;
    logic [8:0]                          w_next_chan;
    logic                                w_last;
    logic                                w_in_acc;
    logic                                w_smp_acc;
    logic                                w_ld_acc;
    logic                                w_out_free;
    logic                                w_take;
    logic                                w_ram_we;
    bni_pkg::t_entry                     w_wr_entry;
    logic [bni_pkg::ENTRY_W-1:0]         w_rdata;
    bni_pkg::t_entry                     w_rd_entry;
    bni_pkg::t_norm_out                  w_norm;
    bni_pkg::t_factor_out                w_fac;

    // Configuration port
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_reg_idx = paddr[bni_pkg::PADDR_W-1:2];

    always_comb begin
        case (w_reg_idx)
            bni_pkg::REG_NUM_CHANNELS: prdata = 32'(r_num_channels);
            bni_pkg::REG_EPSILON:      prdata = 32'(r_epsilon);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_channels <= 9'd1;
            r_epsilon      <= 16'd1;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                bni_pkg::REG_NUM_CHANNELS: r_num_channels <= pwdata[8:0];
                bni_pkg::REG_EPSILON:      r_epsilon      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Channel sequence: clamp the count, restart when the counter is out of range
    always_comb begin
        if (r_num_channels == '0) begin
            w_active = 9'd1;
        end else if (r_num_channels > 9'(bni_pkg::ACT_MAX)) begin
            w_active = 9'(bni_pkg::ACT_MAX);
        end else begin
            w_active = r_num_channels;
        end
    end

    assign w_chan      = ({1'b0, r_counter} >= w_active) ? '0 : r_counter;
    assign w_next_chan = {1'b0, w_chan} + 9'd1;
    assign w_last      = (w_next_chan == w_active);

    // Request acceptance
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_smp_acc  = w_in_acc & (i_in_data.mode == bni_pkg::MODE_SAMPLE);
    assign w_ld_acc   = w_in_acc & (i_in_data.mode == bni_pkg::MODE_LOAD);

    assign w_out_free = ~r_out_valid | i_out_ready;
    assign w_take     = (r_state == ST_NORM) & w_norm.valid & w_out_free;

    // One request in flight; the table write lands before the next read
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_smp_acc) begin
                    n_state = ST_NORM;
                end else if (w_ld_acc) begin
                    n_state = ST_LOAD;
                end
            end
            ST_NORM: begin
                if (w_take) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOAD: begin
                if (w_fac.done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_counter    <= '0;
            r_norm_start <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_norm_start <= w_smp_acc;
            if (w_smp_acc) begin
                r_counter <= w_last ? '0 : w_next_chan[7:0];
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold request fields for the later stages
    always_ff @(posedge i_clk) begin
        if (w_smp_acc) begin
            r_sample   <= i_in_data.sample;
            r_res_chan <= w_chan;
            r_res_last <= w_last;
        end
        if (w_ld_acc) begin
            r_ld_mean  <= i_in_data.mean_value;
            r_ld_shift <= i_in_data.shift_value;
            r_ld_addr  <= bni_pkg::ADDR_W'(i_in_data.load_channel);
            r_ld_ok    <= (32'(i_in_data.load_channel) < bni_pkg::MAX_CHANNELS);
        end
        if (w_take) begin
            r_out <= '{result: w_norm.result, result_channel: r_res_chan,
                       last_channel: r_res_last};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Parameter table: mean, factor and shift per channel
    assign w_ram_we   = w_fac.done & r_ld_ok;
    assign w_wr_entry = '{mean: r_ld_mean, factor: w_fac.factor, shift: r_ld_shift};
    assign w_rd_entry = bni_pkg::t_entry'(w_rdata);

    bni_ram #(
        .WIDTH (bni_pkg::ENTRY_W),
        .DEPTH (bni_pkg::MAX_CHANNELS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_ld_addr),
        .i_wdata (w_wr_entry),
        .i_raddr (bni_pkg::ADDR_W'(w_chan)),
        .o_rdata (w_rdata)
    );

    bni_factor u_factor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_ld_acc),
        .i_variance (i_in_data.variance_value),
        .i_epsilon  (r_epsilon),
        .i_scale    (i_in_data.scale_value),
        .o_res      (w_fac)
    );

    bni_norm u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_norm_start),
        .i_take   (w_take),
        .i_sample (r_sample),
        .i_entry  (w_rd_entry),
        .o_res    (w_norm)
    );

    // Checks
    a_write_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == ST_LOAD))
        else $error("table write outside a load");

    a_norm_in_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_norm.valid |-> (r_state == ST_NORM))
        else $error("normalise result outside a sample");

    a_factor_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fac.done |-> (r_state == ST_LOAD))
        else $error("factor done outside a load");

    a_wrap_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_smp_acc |=> (r_res_last == (r_counter == '0)))
        else $error("channel counter does not wrap on the last channel");

endmodule

`default_nettype wire

// ===== design/bni_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bni_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one port, read the other with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/bni_factor.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bni_factor (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [30:0]           i_variance,
    input  wire logic [15:0]           i_epsilon,
    input  wire logic signed [31:0]    i_scale,
    output bni_pkg::t_factor_out       o_res
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_SQRT = 4'b0010,
        F_DIV  = 4'b0100,
        F_FIN  = 4'b1000
    } t_fstate;

    t_fstate                             r_state;
    logic [bni_pkg::CNT_W-1:0]           r_cnt;
    logic [bni_pkg::X_W-1:0]             r_x;
    logic [bni_pkg::ROOT_W-1:0]          r_rem_sq;
    logic [bni_pkg::ROOT_W-1:0]          r_root;
    logic [bni_pkg::ROOT_W-1:0]          r_rem_dv;
    logic [bni_pkg::DVD_W-1:0]           r_dq;
    logic                                r_neg;
    logic                                r_zero_scale;
    logic signed [bni_pkg::DATA_W-1:0]   r_factor;
    logic                                r_done;

    logic [31:0]                         w_var_sum;
    logic [31:0]                         w_mag;
    logic [bni_pkg::ROOT_W+1:0]          w_sq_sh;
    logic [bni_pkg::ROOT_W+1:0]          w_sq_trial;
    logic                                w_sq_ge;
    logic [bni_pkg::ROOT_W+1:0]          w_sq_rem;
    logic [bni_pkg::ROOT_W-1:0]          w_sq_root;
    logic [bni_pkg::ROOT_W:0]            w_dv_sh;
    logic [bni_pkg::ROOT_W:0]            w_dv_div;
    logic                                w_dv_ge;
    logic [bni_pkg::ROOT_W:0]            w_dv_rem;
    logic                                w_big;
    logic [bni_pkg::DATA_W-1:0]          w_qc;
    logic signed [bni_pkg::DATA_W-1:0]   w_factor;

    // Operand preparation
    assign w_var_sum = 32'(i_variance) + 32'(i_epsilon);
    assign w_mag     = i_scale[31] ? 32'(-i_scale) : 32'(i_scale);

    // One root digit per cycle
    assign w_sq_sh    = {r_rem_sq, r_x[bni_pkg::X_W-1 -: 2]};
    assign w_sq_trial = {r_root, 2'b01};
    assign w_sq_ge    = (w_sq_sh >= w_sq_trial);
    assign w_sq_rem   = w_sq_ge ? (w_sq_sh - w_sq_trial) : w_sq_sh;
    assign w_sq_root  = {r_root[bni_pkg::ROOT_W-2:0], w_sq_ge};

    // One quotient bit per cycle
    assign w_dv_sh  = {r_rem_dv, r_dq[bni_pkg::DVD_W-1]};
    assign w_dv_div = {1'b0, r_root};
    assign w_dv_ge  = (w_dv_sh >= w_dv_div);
    assign w_dv_rem = w_dv_ge ? (w_dv_sh - w_dv_div) : w_dv_sh;

    // Clamp the quotient and apply the sign of scale
    assign w_big = (|r_dq[bni_pkg::DVD_W-1:bni_pkg::DATA_W])
                 | (r_dq[bni_pkg::DATA_W-1] & (|r_dq[bni_pkg::DATA_W-2:0]));
    assign w_qc  = w_big ? bni_pkg::DATA_W'(bni_pkg::SMIN) : r_dq[bni_pkg::DATA_W-1:0];

    always_comb begin
        if (r_root == '0) begin
            if (r_zero_scale) begin
                w_factor = '0;
            end else if (r_neg) begin
                w_factor = bni_pkg::SMIN;
            end else begin
                w_factor = bni_pkg::SMAX;
            end
        end else if (r_neg) begin
            w_factor = signed'(-w_qc);
        end else if (w_qc[bni_pkg::DATA_W-1]) begin
            w_factor = bni_pkg::SMAX;
        end else begin
            w_factor = signed'(w_qc);
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        r_state <= F_SQRT;
                    end
                end
                F_SQRT: begin
                    if (r_cnt == bni_pkg::CNT_W'(1)) begin
                        r_state <= (w_sq_root == '0) ? F_FIN : F_DIV;
                    end
                end
                F_DIV: begin
                    if (r_cnt == bni_pkg::CNT_W'(1)) begin
                        r_state <= F_FIN;
                    end
                end
                F_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    r_x          <= bni_pkg::X_W'(w_var_sum) << bni_pkg::FRAC_BITS;
                    r_dq         <= bni_pkg::DVD_W'(w_mag) << bni_pkg::FRAC_BITS;
                    r_neg        <= i_scale[31];
                    r_zero_scale <= (i_scale == '0);
                    r_rem_sq     <= '0;
                    r_root       <= '0;
                    r_cnt        <= bni_pkg::CNT_W'(bni_pkg::SQ_STEPS);
                end
            end
            F_SQRT: begin
                r_x      <= r_x << 2;
                r_rem_sq <= w_sq_rem[bni_pkg::ROOT_W-1:0];
                r_root   <= w_sq_root;
                r_rem_dv <= '0;
                if (r_cnt == bni_pkg::CNT_W'(1)) begin
                    r_cnt <= bni_pkg::CNT_W'(bni_pkg::DVD_W);
                end else begin
                    r_cnt <= r_cnt - bni_pkg::CNT_W'(1);
                end
            end
            F_DIV: begin
                r_rem_dv <= w_dv_rem[bni_pkg::ROOT_W-1:0];
                r_dq     <= {r_dq[bni_pkg::DVD_W-2:0], w_dv_ge};
                r_cnt    <= r_cnt - bni_pkg::CNT_W'(1);
            end
            F_FIN: begin
                r_factor <= w_factor;
            end
            default: ;
        endcase
    end

    assign o_res = '{done: r_done, factor: r_factor};

endmodule

`default_nettype wire

// ===== design/bni_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bni_norm (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_take,
    input  wire logic signed [31:0]    i_sample,
    input  wire bni_pkg::t_entry       i_entry,
    output bni_pkg::t_norm_out         o_res
);

    logic                                 r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [bni_pkg::DATA_W:0]      r_diff;
    logic signed [bni_pkg::DATA_W-1:0]    r_fac1;
    logic signed [bni_pkg::DATA_W-1:0]    r_sh1, r_sh2, r_sh3, r_sh4;
    logic [bni_pkg::DATA_W:0]             r_dm;
    logic [bni_pkg::DATA_W-1:0]           r_fm;
    logic                                 r_neg2, r_neg3, r_neg4;
    logic [bni_pkg::PH_W-1:0]             r_ph;
    logic [bni_pkg::PL_W-1:0]             r_pl;
    logic [bni_pkg::PM_W-1:0]             r_pm;
    logic signed [bni_pkg::DATA_W-1:0]    r_res;

    logic [bni_pkg::DH_W-1:0]             w_dm_hi;
    logic [bni_pkg::FRAC_BITS-1:0]        w_dm_lo;
    logic signed [bni_pkg::SUM_W-1:0]     w_pm_s;
    logic signed [bni_pkg::SUM_W-1:0]     w_sh_s;
    logic signed [bni_pkg::SUM_W-1:0]     w_sum;
    logic                                 w_fits;
    logic signed [bni_pkg::DATA_W-1:0]    w_sat;

    assign w_dm_hi = r_dm[bni_pkg::DATA_W:bni_pkg::FRAC_BITS];
    assign w_dm_lo = r_dm[bni_pkg::FRAC_BITS-1:0];

    // Add or subtract the product around shift, then saturate
    assign w_pm_s = signed'({1'b0, r_pm});
    assign w_sh_s = bni_pkg::SUM_W'(r_sh4);
    assign w_sum  = r_neg4 ? (w_sh_s - w_pm_s) : (w_sh_s + w_pm_s);
    assign w_fits = (&w_sum[bni_pkg::SUM_W-1:bni_pkg::DATA_W-1])
                  | ~(|w_sum[bni_pkg::SUM_W-1:bni_pkg::DATA_W-1]);
    assign w_sat  = w_fits ? w_sum[bni_pkg::DATA_W-1:0]
                  : (w_sum[bni_pkg::SUM_W-1] ? bni_pkg::SMIN : bni_pkg::SMAX);

    // Stage valids; hold the last stage until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4 | (r_v5 & ~i_take);
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        // difference to the channel mean
        if (i_start) begin
            r_diff <= (bni_pkg::DATA_W+1)'(i_sample) - (bni_pkg::DATA_W+1)'(i_entry.mean);
            r_fac1 <= i_entry.factor;
            r_sh1  <= i_entry.shift;
        end
        // magnitudes and result sign
        if (r_v1) begin
            r_dm   <= r_diff[bni_pkg::DATA_W] ? (bni_pkg::DATA_W+1)'(-r_diff)
                                              : (bni_pkg::DATA_W+1)'(r_diff);
            r_fm   <= r_fac1[bni_pkg::DATA_W-1] ? bni_pkg::DATA_W'(-r_fac1)
                                                : bni_pkg::DATA_W'(r_fac1);
            r_neg2 <= r_diff[bni_pkg::DATA_W] ^ r_fac1[bni_pkg::DATA_W-1];
            r_sh2  <= r_sh1;
        end
        // two partial products
        if (r_v2) begin
            r_ph  <= w_dm_hi * r_fm;
            r_pl  <= w_dm_lo * r_fm;
            r_neg3 <= r_neg2;
            r_sh3  <= r_sh2;
        end
        // product shifted down by the fraction width
        if (r_v3) begin
            r_pm   <= r_ph + bni_pkg::PM_W'(r_pl[bni_pkg::PL_W-1:bni_pkg::FRAC_BITS]);
            r_neg4 <= r_neg3;
            r_sh4  <= r_sh3;
        end
        if (r_v4) begin
            r_res <= w_sat;
        end
    end

    assign o_res = '{valid: r_v5, result: r_res};

endmodule

`default_nettype wire

// ===== verif/tb_batch_norm_inference_core.sv =====
`timescale 1ns / 1ps

module tb_batch_norm_inference_core;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS     = 10;
    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // Block ports
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    bni_pkg::t_in_item           in_data  = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    bni_pkg::t_out_item          out_data;
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [bni_pkg::PADDR_W-1:0] paddr    = '0;
    logic [31:0]                 pwdata   = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    batch_norm_inference_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Shadow of the channel tables, counter and registers
    logic signed [31:0] mean_tbl   [bni_pkg::MAX_CHANNELS];
    logic signed [31:0] factor_tbl [bni_pkg::MAX_CHANNELS];
    logic signed [31:0] shift_tbl  [bni_pkg::MAX_CHANNELS];
    bit                 chan_loaded [bni_pkg::MAX_CHANNELS];
    int unsigned        chan_count = 0;
    logic [8:0]         num_ch_reg = 9'd1;
    logic [15:0]        eps_reg    = 16'd1;
    bni_pkg::t_out_item expected_norm_q [$];

    // Traffic shaping
    int send_idle_pct    = 0;
    int stall_pct        = 0;
    int hold_off_request = 0;
    int hold_left        = 0;
    int idle_cycles      = 0;

    // Tallies
    int mismatches    = 0;
    int checked_count = 0;
    int load_count    = 0;
    int sample_count  = 0;
    int setting_count = 0;

    // Integer square root, bit by bit
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scale / sqrt(variance + epsilon), truncated, signed and clamped
    function automatic logic signed [31:0] compute_factor(input logic [30:0] variance,
                                                          input logic signed [31:0] scale);
        longint unsigned root;
        longint unsigned mag;
        longint unsigned quo;
        longint          sc;
        sc   = longint'(scale);
        root = int_sqrt((longint'(variance) + longint'(eps_reg)) << bni_pkg::FRAC_BITS);
        // zero root: pin to the rail that matches the sign of scale
        if (root == 0) begin
            if (sc > 0) return bni_pkg::SMAX;
            if (sc < 0) return bni_pkg::SMIN;
            return '0;
        end
        mag = (sc < 0) ? -sc : sc;
        quo = (mag << bni_pkg::FRAC_BITS) / root;
        if (quo > 64'h8000_0000) quo = 64'h8000_0000;
        if (sc < 0) return 32'(0 - quo);
        if (quo > 64'h7FFF_FFFF) return bni_pkg::SMAX;
        return 32'(quo);
    endfunction

    // (sample - mean) * factor >> FRAC_BITS toward zero, plus shift, saturated
    function automatic logic signed [31:0] normalised_value(input int unsigned c,
                                                            input logic signed [31:0] value);
        longint          diff;
        longint          fac;
        longint          scaled;
        longint          sum;
        longint unsigned dm;
        longint unsigned fm;
        longint unsigned pm;
        diff   = longint'(value) - longint'(mean_tbl[c]);
        fac    = longint'(factor_tbl[c]);
        dm     = (diff < 0) ? -diff : diff;
        fm     = (fac < 0) ? -fac : fac;
        pm     = (dm * fm) >> bni_pkg::FRAC_BITS;
        scaled = ((diff < 0) != (fac < 0)) ? -longint'(pm) : longint'(pm);
        sum    = scaled + longint'(shift_tbl[c]);
        if (sum > longint'(bni_pkg::SMAX)) return bni_pkg::SMAX;
        if (sum < longint'(bni_pkg::SMIN)) return bni_pkg::SMIN;
        return 32'(sum);
    endfunction

    // Channel count in force: zero acts as one, clamp to the table size
    function automatic int unsigned active_count();
        int unsigned n;
        n = num_ch_reg;
        if (n == 0) n = 1;
        if (n > bni_pkg::MAX_CHANNELS) n = bni_pkg::MAX_CHANNELS;
        if (n > 256) n = 256;
        return n;
    endfunction

    function automatic int unsigned next_channel();
        return (chan_count >= active_count()) ? 0 : chan_count;
    endfunction

    // Advance the shadow state by one accepted request
    function automatic void apply_request(input bni_pkg::t_in_item req);
        int unsigned        c;
        int unsigned        n;
        bni_pkg::t_out_item exp_item;
        if (req.mode == bni_pkg::MODE_LOAD) begin
            if (req.load_channel < bni_pkg::MAX_CHANNELS) begin
                mean_tbl[req.load_channel]    = req.mean_value;
                factor_tbl[req.load_channel]  = compute_factor(req.variance_value,
                                                               req.scale_value);
                shift_tbl[req.load_channel]   = req.shift_value;
                chan_loaded[req.load_channel] = 1'b1;
            end
            load_count++;
        end else begin
            n = active_count();
            c = next_channel();
            exp_item.result         = normalised_value(c, req.sample);
            exp_item.result_channel = 8'(c);
            exp_item.last_channel   = (c + 1 == n);
            chan_count = (c + 1 == n) ? 0 : c + 1;
            expected_norm_q.push_back(exp_item);
            sample_count++;
        end
    endfunction

    // Random Q16.16 word: mostly moderate, sometimes full range, a rail, zero or all ones
    function automatic logic signed [31:0] rand_fixed();
        case ($urandom_range(9))
            0: return $urandom;
            1: begin
                case ($urandom_range(3))
                    0: return bni_pkg::SMAX;
                    1: return bni_pkg::SMIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [30:0] rand_variance();
        case ($urandom_range(7))
            0: return 31'($urandom);
            1: return ($urandom_range(1) != 0) ? 31'h7FFF_FFFF : 31'h0;
            2, 3: return 31'($urandom_range(32'h0000_4000));
            default: return 31'($urandom_range(32'h0000_1000, 32'h0010_0000));
        endcase
    endfunction

    // Offer one request, with random idle cycles ahead of it
    task automatic send_request(input bni_pkg::t_in_item req);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (!in_ready);
        apply_request(req);
    endtask

    task automatic send_load(input logic [7:0] ch, input logic signed [31:0] mean,
                             input logic [30:0] variance, input logic signed [31:0] scale,
                             input logic signed [31:0] shift);
        bni_pkg::t_in_item req;
        req.mode           = bni_pkg::MODE_LOAD;
        req.load_channel   = ch;
        req.mean_value     = mean;
        req.variance_value = variance;
        req.scale_value    = scale;
        req.shift_value    = shift;
        req.sample         = $urandom;
        send_request(req);
    endtask

    task automatic load_random(input logic [7:0] ch);
        send_load(ch, rand_fixed(), rand_variance(), rand_fixed(), rand_fixed());
    endtask

    // Sample request; load its channel first if it has never been written
    task automatic send_sample(input logic signed [31:0] value);
        bni_pkg::t_in_item req;
        int unsigned       c;
        c = next_channel();
        if (!chan_loaded[c]) load_random(8'(c));
        req.mode           = bni_pkg::MODE_SAMPLE;
        req.load_channel   = 8'($urandom);
        req.mean_value     = $urandom;
        req.variance_value = 31'($urandom);
        req.scale_value    = $urandom;
        req.shift_value    = $urandom;
        req.sample         = value;
        send_request(req);
    endtask

    // Drop valid and hold until every expected result has arrived
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_norm_q.size() != 0) @(posedge i_clk);
    endtask

    // Drain, then let any load still in the root and divide unit finish
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup cycle, access cycle, then idle with psel low
    task automatic write_reg(input logic [bni_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == bni_pkg::REG_NUM_CHANNELS) begin
            num_ch_reg = value[8:0];
        end else if (idx == bni_pkg::REG_EPSILON) begin
            eps_reg = value[15:0];
        end
        setting_count++;
        @(posedge i_clk);
    endtask

    // Reset values of both registers, one channel
    task automatic test_reset_settings();
        send_load(8'd0, 32'sh0000_8000, 31'h0001_0000, ONE_Q16, 32'sh0002_0000);
        send_sample(ONE_Q16);
        send_sample('0);
        send_sample(bni_pkg::SMAX);
    endtask

    // Zero root with each sign of scale, factor clamp, output saturation
    task automatic test_zero_root();
        settle();
        write_reg(bni_pkg::REG_EPSILON, 32'd0);
        write_reg(bni_pkg::REG_NUM_CHANNELS, 32'd4);
        send_load(8'd0, bni_pkg::SMIN, 31'h0, 32'sh0002_0000, '0);
        send_load(8'd1, ONE_Q16, 31'h0, -32'sh0001_8000, 32'sh0000_4000);
        send_load(8'd2, bni_pkg::SMAX, 31'h0, '0, 32'sh0003_0000);
        send_load(8'd3, '0, 31'h1, bni_pkg::SMIN, '0);
        send_sample(bni_pkg::SMAX);
        send_sample(bni_pkg::SMIN);
        send_sample(bni_pkg::SMAX);
        send_sample(ONE_Q16);
        send_sample(-ONE_Q16);
        send_sample(ONE_Q16);
        send_sample('0);
        send_sample(bni_pkg::SMIN);
    endtask

    // Field rails, largest epsilon, load in the middle of a pixel
    task automatic test_field_extremes();
        settle();
        write_reg(bni_pkg::REG_EPSILON, 32'd65535);
        write_reg(bni_pkg::REG_NUM_CHANNELS, 32'd2);
        send_load(8'd0, bni_pkg::SMAX, 31'h7FFF_FFFF, bni_pkg::SMIN, bni_pkg::SMIN);
        send_load(8'd1, bni_pkg::SMIN, 31'h1, bni_pkg::SMAX, bni_pkg::SMAX);
        send_sample(bni_pkg::SMIN);
        send_sample(bni_pkg::SMAX);
        send_sample(32'sh0000_0001);
        // counter must stay on channel 1 across this load
        send_load(8'd255, -32'sh0000_2000, 31'h0002_0000, 32'sh0000_C000, -ONE_Q16);
        send_load(8'd1, 32'sh0001_0000, 31'h0000_4000, -32'sh0004_0000, 32'sh0000_0100);
        send_sample('0);
        send_sample('1);
    endtask

    // Channel count zero, and a count shrunk below the running counter
    task automatic test_channel_count_limits();
        settle();
        write_reg(bni_pkg::REG_NUM_CHANNELS, 32'd0);
        send_sample(ONE_Q16);
        send_sample(-ONE_Q16);
        settle();
        write_reg(bni_pkg::REG_NUM_CHANNELS, 32'd6);
        repeat (4) send_sample(rand_fixed());
        settle();
        write_reg(bni_pkg::REG_NUM_CHANNELS, 32'd2);
        repeat (3) send_sample(rand_fixed());
    endtask

    // Random loads and samples under one setting and one idling mix
    task automatic test_random_traffic(input int idle, input int stall, input logic [8:0] nch,
                                       input logic [15:0] eps, input int n_samples);
        int sent;
        settle();
        write_reg(bni_pkg::REG_NUM_CHANNELS, 32'(nch));
        write_reg(bni_pkg::REG_EPSILON, 32'(eps));
        send_idle_pct = idle;
        stall_pct     = stall;
        sent          = 0;
        while (sent < n_samples) begin
            if ($urandom_range(99) < 12) begin
                load_random(8'($urandom_range(255)));
            end else begin
                send_sample(rand_fixed());
                sent++;
            end
        end
        wait_drained();
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // Long receiver hold-off while samples keep being offered, then a drain and five more samples
    task automatic test_output_backpressure();
        wait_drained();
        send_idle_pct    = 0;
        stall_pct        = 0;
        hold_off_request = HOLD_OFF_CYCLES;
        repeat (30) send_sample(rand_fixed());
        wait_drained();
        repeat (5) send_sample(rand_fixed());
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_off_request != 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_val, act_val);
        end
    endtask

    // Compare each result against the oldest expectation
    always @(posedge i_clk) begin
        bni_pkg::t_out_item exp_item;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_norm_q.size() == 0) begin
                note_mismatch("unexpected result", '0, out_data.result);
            end else begin
                exp_item = expected_norm_q.pop_front();
                checked_count++;
                if (out_data.result !== exp_item.result) begin
                    note_mismatch("result", exp_item.result, out_data.result);
                end
                if (out_data.result_channel !== exp_item.result_channel) begin
                    note_mismatch("result_channel", 32'(exp_item.result_channel),
                                  32'(out_data.result_channel));
                end
                if (out_data.last_channel !== exp_item.last_channel) begin
                    note_mismatch("last_channel", 32'(exp_item.last_channel),
                                  32'(out_data.last_channel));
                end
            end
        end
    end

    // Watchdog: end the run after too long without any handshake
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("batch_norm_inference_core verification failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_settings();
        test_zero_root();
        test_field_extremes();
        test_channel_count_limits();
        test_random_traffic(0, 0, 9'd511, 16'($urandom_range(65535)), 40);
        test_random_traffic(61, 0, 9'($urandom_range(2, 16)), 16'd0, 60);
        test_random_traffic(0, 61, 9'd256, 16'd65535, 60);
        test_random_traffic(28, 28, 9'($urandom_range(1, 300)), 16'd1, 60);
        test_output_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d parameter loads and %0d samples over %0d register writes;",
                 load_count, sample_count, setting_count);
        $display("%0d results compared, %0d mismatches (zero root, rails, counts 0..511, hold-off).",
                 checked_count, mismatches);
        if (mismatches == 0 && expected_norm_q.size() == 0) begin
            $display("batch_norm_inference_core verification clean");
        end else begin
            $display("batch_norm_inference_core verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bni_pkg.sv
design/bni_ram.sv
design/bni_factor.sv
design/bni_norm.sv
design/batch_norm_inference_core.sv
verif/tb_batch_norm_inference_core.sv
